[src/binary_min_heap_queue_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the binary min-heap queue
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BMHQ_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMHQ_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BMHQ_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define BMHQ_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

[src/bmhq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Field widths, request and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int REQ_W   = 3;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 8;
  localparam int OP_W    = 4;

  typedef logic [REQ_W-1:0]          req_t;
  typedef logic signed [KEY_W-1:0]   key_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [STAT_W-1:0]         stat_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [OP_W-1:0]           op_t;

  localparam req_t REQ_INSERT   = 3'd0;
  localparam req_t REQ_EXTRACT  = 3'd1;
  localparam req_t REQ_PEEK     = 3'd2;
  localparam req_t REQ_DECREASE = 3'd3;
  localparam req_t REQ_DELETE   = 3'd4;

  localparam stat_t ST_OK     = 3'd0;
  localparam stat_t ST_EMPTY  = 3'd1;
  localparam stat_t ST_FULL   = 3'd2;
  localparam stat_t ST_BADPOS = 3'd3;
  localparam stat_t ST_LARGER = 3'd4;

  // datapath micro-operations
  localparam op_t OP_NOP       = 4'd0;
  localparam op_t OP_INSERT    = 4'd1;
  localparam op_t OP_RD_TOP    = 4'd2;
  localparam op_t OP_RD_POS    = 4'd3;
  localparam op_t OP_RD_LAST   = 4'd4;
  localparam op_t OP_PEEK      = 4'd5;
  localparam op_t OP_EXTRACT   = 4'd6;
  localparam op_t OP_DEC_CHECK = 4'd7;
  localparam op_t OP_DEL_GO    = 4'd8;
  localparam op_t OP_DN_STEP   = 4'd9;
  localparam op_t OP_RD_PARENT = 4'd10;
  localparam op_t OP_UP_STEP   = 4'd11;
  localparam op_t OP_RES_LOAD  = 4'd12;

  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic imm_fail;
    logic larger;
    logic in_range;
    logic dn_stop;
    logic at_start;
    logic up_stop;
  } sts_t;

endpackage

[src/bmhq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmhq_in_if;
  logic               valid;
  logic               ready;
  bmhq_pkg::req_t     req_type;
  bmhq_pkg::key_t     key;
  bmhq_pkg::pos_t     position;

  modport source (output valid, output req_type, output key, output position, input ready);
  modport sink   (input valid, input req_type, input key, input position, output ready);
endinterface

interface bmhq_out_if;
  logic               valid;
  logic               ready;
  bmhq_pkg::stat_t    status;
  bmhq_pkg::key_t     key_out;
  bmhq_pkg::count_t   count_out;

  modport source (output valid, output status, output key_out, output count_out, input ready);
  modport sink   (input valid, input status, input key_out, input count_out, output ready);
endinterface

[src/bmhq_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_dpath
// Heap memory, element count, sift position and moving key, result registers.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_assert.svh"

module bmhq_dpath #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bmhq_pkg::req_t     in_req_type,
  input  bmhq_pkg::key_t     in_key,
  input  bmhq_pkg::pos_t     in_position,
  input  bmhq_pkg::cmd_t     cmd,
  output bmhq_pkg::sts_t     sts,
  output bmhq_pkg::stat_t    res_status,
  output bmhq_pkg::key_t     res_key,
  output bmhq_pkg::count_t   res_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = IDX_W + 2;
  localparam int PC_W  = bmhq_pkg::POS_W + CNT_W;
  localparam int PW_W  = bmhq_pkg::POS_W + IDX_W;
  localparam int CW_W  = CNT_W + bmhq_pkg::COUNT_W;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CH_W-1:0]  ch_t;

  // heap memory: one write port, two registered read ports
  bmhq_pkg::key_t mem [CAPACITY];
  bmhq_pkg::key_t rd0_r, rd1_r;
  idx_t           ra0, ra1, wa;
  bmhq_pkg::key_t wd;
  logic           we;

  cnt_t            count_r, count_nxt;
  idx_t            pos_r, pos_nxt;
  idx_t            start_r, start_nxt;
  bmhq_pkg::key_t  key_r, key_nxt;
  bmhq_pkg::stat_t status_r, status_nxt;
  bmhq_pkg::key_t  kout_r, kout_nxt;
  bmhq_pkg::stat_t res_status_r, res_status_nxt;
  bmhq_pkg::key_t  res_key_r, res_key_nxt;
  bmhq_pkg::count_t res_count_r, res_count_nxt;

  logic            full, empty, badpos;
  bmhq_pkg::stat_t st_imm;
  logic [PW_W-1:0] pos_wide;
  idx_t            pos_in_idx, cnt_idx, cnt_m1;
  idx_t            p_par, par_par;
  ch_t             cnt_ext, l_ch, r_ch, cl_ch, cr_ch;
  logic            lv, rv, take_l, take_r;
  bmhq_pkg::key_t  best, dn_val;
  idx_t            dn_child;
  logic            dn_stop, up_stop;
  logic [CW_W-1:0] cnt_wide;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_comb begin
    full   = (count_r == CNT_W'(CAPACITY));
    empty  = (count_r == '0);
    badpos = (PC_W'(in_position) >= PC_W'(count_r));
    st_imm = bmhq_pkg::ST_OK;
    unique case (in_req_type)
      bmhq_pkg::REQ_INSERT:   if (full)   st_imm = bmhq_pkg::ST_FULL;
      bmhq_pkg::REQ_EXTRACT,
      bmhq_pkg::REQ_PEEK:     if (empty)  st_imm = bmhq_pkg::ST_EMPTY;
      bmhq_pkg::REQ_DECREASE,
      bmhq_pkg::REQ_DELETE:   if (badpos) st_imm = bmhq_pkg::ST_BADPOS;
      default:                st_imm = bmhq_pkg::ST_OK;
    endcase
  end

  always_comb begin
    pos_wide   = PW_W'(in_position);
    pos_in_idx = pos_wide[IDX_W-1:0];
    cnt_idx    = count_r[IDX_W-1:0];
    cnt_m1     = cnt_idx - IDX_W'(1);
    p_par      = (pos_r - IDX_W'(1)) >> 1;
    par_par    = (p_par - IDX_W'(1)) >> 1;

    // sift-down choice: left wins ties with right
    cnt_ext  = CH_W'(count_r);
    l_ch     = CH_W'({pos_r, 1'b1});
    r_ch     = l_ch + CH_W'(1);
    lv       = (l_ch < cnt_ext);
    rv       = (r_ch < cnt_ext);
    take_l   = lv && (rd0_r < key_r);
    best     = take_l ? rd0_r : key_r;
    take_r   = rv && (rd1_r < best);
    dn_stop  = !take_l && !take_r;
    dn_child = take_r ? r_ch[IDX_W-1:0] : l_ch[IDX_W-1:0];
    dn_val   = take_r ? rd1_r : rd0_r;
    cl_ch    = CH_W'({dn_child, 1'b1});
    cr_ch    = cl_ch + CH_W'(1);

    up_stop  = (pos_r == '0) || (key_r >= rd0_r);

    cnt_wide = CW_W'(count_r);
  end

  always_comb begin
    sts.imm_fail = (st_imm != bmhq_pkg::ST_OK);
    sts.larger   = (key_r > rd0_r);
    sts.in_range = (CH_W'(pos_r) < cnt_ext);
    sts.dn_stop  = dn_stop;
    sts.at_start = (pos_r == start_r);
    sts.up_stop  = up_stop;
  end

  always_comb begin
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    start_nxt      = start_r;
    key_nxt        = key_r;
    status_nxt     = status_r;
    kout_nxt       = kout_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_count_nxt  = res_count_r;
    ra0            = '0;
    ra1            = '0;
    wa             = pos_r;
    wd             = key_r;
    we             = 1'b0;

    if (cmd.capture) begin
      status_nxt = st_imm;
      kout_nxt   = '0;
      key_nxt    = in_key;
      pos_nxt    = pos_in_idx;
    end

    unique case (cmd.op)
      bmhq_pkg::OP_INSERT: begin
        pos_nxt   = cnt_idx;
        count_nxt = count_r + CNT_W'(1);
        ra0       = (cnt_idx - IDX_W'(1)) >> 1;
      end
      bmhq_pkg::OP_RD_TOP: begin
        ra0 = '0;
        ra1 = cnt_m1;
      end
      bmhq_pkg::OP_RD_POS: begin
        ra0 = pos_in_idx;
      end
      bmhq_pkg::OP_RD_LAST: begin
        ra1       = cnt_m1;
        count_nxt = count_r - CNT_W'(1);
      end
      bmhq_pkg::OP_PEEK: begin
        kout_nxt = rd0_r;
      end
      bmhq_pkg::OP_EXTRACT: begin
        kout_nxt  = rd0_r;
        key_nxt   = rd1_r;
        count_nxt = count_r - CNT_W'(1);
        pos_nxt   = '0;
        ra0       = IDX_W'(1);
        ra1       = IDX_W'(2);
      end
      bmhq_pkg::OP_DEC_CHECK: begin
        if (sts.larger) begin
          status_nxt = bmhq_pkg::ST_LARGER;
        end
        ra0 = p_par;
      end
      bmhq_pkg::OP_DEL_GO: begin
        key_nxt   = rd1_r;
        start_nxt = pos_r;
        ra0       = l_ch[IDX_W-1:0];
        ra1       = r_ch[IDX_W-1:0];
      end
      bmhq_pkg::OP_DN_STEP: begin
        we = 1'b1;
        if (!dn_stop) begin
          wd      = dn_val;
          pos_nxt = dn_child;
          ra0     = cl_ch[IDX_W-1:0];
          ra1     = cr_ch[IDX_W-1:0];
        end
      end
      bmhq_pkg::OP_RD_PARENT: begin
        ra0 = p_par;
      end
      bmhq_pkg::OP_UP_STEP: begin
        we = 1'b1;
        if (!up_stop) begin
          wd      = rd0_r;
          pos_nxt = p_par;
          ra0     = par_par;
        end
      end
      bmhq_pkg::OP_RES_LOAD: begin
        res_status_nxt = status_r;
        res_key_nxt    = kout_r;
        res_count_nxt  = cnt_wide[bmhq_pkg::COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    start_r      <= start_nxt;
    key_r        <= key_nxt;
    status_r     <= status_nxt;
    kout_r       <= kout_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_count_r  <= res_count_nxt;
  end

  assign res_status = res_status_r;
  assign res_key    = res_key_r;
  assign res_count  = res_count_r;

  `BMHQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, CH_W'(count_r) <= CH_W'(CAPACITY), "element count above capacity")
  `BMHQ_ASSERT_NXT(a_up_climbs, clk, rst_n, (cmd.op == bmhq_pkg::OP_UP_STEP) && !up_stop, pos_r < $past(pos_r), "sift up did not move toward the root")
  `BMHQ_ASSERT_NXT(a_dn_descends, clk, rst_n, (cmd.op == bmhq_pkg::OP_DN_STEP) && !dn_stop, pos_r > $past(pos_r), "sift down did not move toward the leaves")

endmodule

[src/bmhq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Request sequencer: fetch, sift down, sift up and result handoff.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_assert.svh"

module bmhq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bmhq_pkg::req_t  in_req_type,
  output logic            out_valid,
  input  logic            out_ready,
  input  bmhq_pkg::sts_t  sts,
  output bmhq_pkg::cmd_t  cmd
);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
  localparam logic [STATE_W-1:0] S_FETCH = 3'd1;
  localparam logic [STATE_W-1:0] S_DOWN  = 3'd2;
  localparam logic [STATE_W-1:0] S_UP    = 3'd3;
  localparam logic [STATE_W-1:0] S_RESP  = 3'd4;

  logic [STATE_W-1:0] state_r, state_nxt;
  bmhq_pkg::req_t     req_r, req_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          req_nxt     = in_req_type;
          if (sts.imm_fail) begin
            state_nxt = S_RESP;
          end else begin
            unique case (in_req_type)
              bmhq_pkg::REQ_INSERT: begin
                cmd.op    = bmhq_pkg::OP_INSERT;
                state_nxt = S_UP;
              end
              bmhq_pkg::REQ_EXTRACT,
              bmhq_pkg::REQ_PEEK: begin
                cmd.op    = bmhq_pkg::OP_RD_TOP;
                state_nxt = S_FETCH;
              end
              bmhq_pkg::REQ_DECREASE: begin
                cmd.op    = bmhq_pkg::OP_RD_POS;
                state_nxt = S_FETCH;
              end
              bmhq_pkg::REQ_DELETE: begin
                cmd.op    = bmhq_pkg::OP_RD_LAST;
                state_nxt = S_FETCH;
              end
              default: state_nxt = S_RESP;
            endcase
          end
        end
      end
      S_FETCH: begin
        unique case (req_r)
          bmhq_pkg::REQ_PEEK: begin
            cmd.op    = bmhq_pkg::OP_PEEK;
            state_nxt = S_RESP;
          end
          bmhq_pkg::REQ_EXTRACT: begin
            cmd.op    = bmhq_pkg::OP_EXTRACT;
            state_nxt = S_DOWN;
          end
          bmhq_pkg::REQ_DECREASE: begin
            cmd.op    = bmhq_pkg::OP_DEC_CHECK;
            state_nxt = sts.larger ? S_RESP : S_UP;
          end
          bmhq_pkg::REQ_DELETE: begin
            // deleting the last slot needs no repair
            cmd.op    = bmhq_pkg::OP_DEL_GO;
            state_nxt = sts.in_range ? S_DOWN : S_RESP;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_DOWN: begin
        priority if (!sts.dn_stop) begin
          cmd.op = bmhq_pkg::OP_DN_STEP;
        end else if ((req_r == bmhq_pkg::REQ_DELETE) && sts.at_start) begin
          // moved key did not sink, so try to raise it
          cmd.op    = bmhq_pkg::OP_RD_PARENT;
          state_nxt = S_UP;
        end else begin
          cmd.op    = bmhq_pkg::OP_DN_STEP;
          state_nxt = S_RESP;
        end
      end
      S_UP: begin
        cmd.op = bmhq_pkg::OP_UP_STEP;
        if (sts.up_stop) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = bmhq_pkg::OP_RES_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  `BMHQ_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != S_IDLE, "request transfer did not start work")
  `BMHQ_ASSERT_IMP(a_load_free_slot, clk, rst_n, cmd.op == bmhq_pkg::OP_RES_LOAD, !out_valid_r || out_ready, "result overwrote a pending transfer")
  `BMHQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r, "result dropped before transfer")

endmodule

[src/binary_min_heap_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue of signed keys: insert, extract, peek,
// decrease key and delete at position, one result per request.
// ----------------------------------------------------------------------------
// a rejected or unknown request goes straight from the request transfer to
//   the result load, a peek reads the root first, a delete may sift both ways
// one request in flight; the sift walks one tree level per cycle through
//   the heap memory's registered read ports, which sets the rate
// throughput: next request taken in the cycle after the result is loaded
// reset: synchronous active low, empties the heap; memory is not cleared
module binary_min_heap_queue #(
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  bmhq_in_if.sink     in_ch,
  bmhq_out_if.source  out_ch
);

  bmhq_pkg::cmd_t cmd;
  bmhq_pkg::sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  bmhq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req_type (in_ch.req_type),
    .in_key      (in_ch.key),
    .in_position (in_ch.position),
    .cmd         (cmd),
    .sts         (sts),
    .res_status  (out_ch.status),
    .res_key     (out_ch.key_out),
    .res_count   (out_ch.count_out)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_min_heap_queue. A tracker class keeps its
// own copy of the heap, predicts status, key and count for every request
// that is taken, and matches them in order against the result channel.
// Directed corner requests come first, then phases of random traffic that
// fill, churn and drain the heap under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

localparam int HEAP_SLOTS = 128;

typedef struct packed {
  bmhq_pkg::stat_t  status;
  bmhq_pkg::key_t   key_out;
  bmhq_pkg::count_t count_out;
} heap_result_t;

class heap_tracker;
  bmhq_pkg::key_t heap_keys[HEAP_SLOTS];
  int unsigned    key_count;
  heap_result_t   pending_results[$];
  int unsigned    mismatches;

  function new();
    key_count   = 0;
    mismatches  = 0;
  endfunction

  function void swap_slots(int unsigned a, int unsigned b);
    bmhq_pkg::key_t t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function void sift_up(int unsigned p);
    int unsigned up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (heap_keys[p] >= heap_keys[up]) break;
      swap_slots(p, up);
      p = up;
    end
  endfunction

  function void sift_down(int unsigned p);
    int unsigned l, r, m;
    forever begin
      l = 2 * p + 1;
      r = 2 * p + 2;
      m = p;
      if (l < key_count && heap_keys[l] < heap_keys[m]) m = l;
      if (r < key_count && heap_keys[r] < heap_keys[m]) m = r;
      if (m == p) break;
      swap_slots(p, m);
      p = m;
    end
  endfunction

  // work out the result of one taken request and queue it
  function void note_request(bmhq_pkg::req_t req, bmhq_pkg::key_t key, bmhq_pkg::pos_t pos);
    heap_result_t res;
    res.status  = bmhq_pkg::ST_OK;
    res.key_out = '0;
    case (req)
      bmhq_pkg::REQ_INSERT: begin
        if (key_count >= HEAP_SLOTS) begin
          res.status = bmhq_pkg::ST_FULL;
        end else begin
          heap_keys[key_count] = key;
          key_count++;
          sift_up(key_count - 1);
        end
      end
      bmhq_pkg::REQ_EXTRACT, bmhq_pkg::REQ_PEEK: begin
        if (key_count == 0) begin
          res.status = bmhq_pkg::ST_EMPTY;
        end else begin
          res.key_out = heap_keys[0];
          if (req == bmhq_pkg::REQ_EXTRACT) begin
            key_count--;
            heap_keys[0] = heap_keys[key_count];
            sift_down(0);
          end
        end
      end
      bmhq_pkg::REQ_DECREASE: begin
        if (pos >= key_count) begin
          res.status = bmhq_pkg::ST_BADPOS;
        end else if (key > heap_keys[pos]) begin
          res.status = bmhq_pkg::ST_LARGER;
        end else begin
          heap_keys[pos] = key;
          sift_up(pos);
        end
      end
      bmhq_pkg::REQ_DELETE: begin
        if (pos >= key_count) begin
          res.status = bmhq_pkg::ST_BADPOS;
        end else begin
          key_count--;
          if (pos < key_count) begin
            heap_keys[pos] = heap_keys[key_count];
            sift_down(pos);
            sift_up(pos);
          end
        end
      end
      default: ;
    endcase
    res.count_out = bmhq_pkg::count_t'(key_count);
    pending_results.push_back(res);
  endfunction

  function void check_result(bmhq_pkg::stat_t status, bmhq_pkg::key_t key_out,
                             bmhq_pkg::count_t count_out);
    heap_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("result with nothing pending: status %0d key_out %0d count_out %0d",
             status, key_out, count_out);
      mismatches++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (status !== exp_res.status) begin
      $error("status: expected %0d, actual %0d", exp_res.status, status);
      mismatches++;
    end
    if (key_out !== exp_res.key_out) begin
      $error("key_out: expected %0d, actual %0d", exp_res.key_out, key_out);
      mismatches++;
    end
    if (count_out !== exp_res.count_out) begin
      $error("count_out: expected %0d, actual %0d", exp_res.count_out, count_out);
      mismatches++;
    end
  endfunction
endclass

module tb;
  localparam bmhq_pkg::key_t KEY_MAX    = 32'sh7FFF_FFFF;
  localparam bmhq_pkg::key_t KEY_MIN    = 32'sh8000_0000;
  localparam bmhq_pkg::req_t REQ_RSVD_A = 3'd5;
  localparam bmhq_pkg::req_t REQ_RSVD_B = 3'd6;
  localparam bmhq_pkg::req_t REQ_RSVD_C = 3'd7;
  localparam int   STALL_LIMIT   = 4000;
  localparam int   END_SETTLE    = 40;
  localparam int   RX_MODE_SPAN  = 200;

  logic clk;
  logic rst_n;

  bmhq_in_if  in_ch();
  bmhq_out_if out_ch();

  binary_min_heap_queue #(.CAPACITY(HEAP_SLOTS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  heap_tracker tracker = new();

  int burst_left;
  int rx_mode        = 0;
  int rx_cnt         = 0;
  int rx_period      = 4;
  int rx_duty        = 2;
  int stalled_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: checks every transfer, stalls on a pattern that changes now and then
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result(out_ch.status, out_ch.key_out, out_ch.count_out);
    rx_cnt = rx_cnt + 1;
    if (rx_cnt % RX_MODE_SPAN == 0) begin
      rx_mode   = $urandom_range(0, 2);
      rx_period = $urandom_range(2, 8);
      rx_duty   = $urandom_range(1, rx_period - 1);
    end
    case (rx_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= (rx_cnt % rx_period) < rx_duty;
      default: out_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("binary_min_heap_queue: mismatch");
      $finish;
    end
  end

  task automatic push_request(input bmhq_pkg::req_t req, input bmhq_pkg::key_t key,
                              input bmhq_pkg::pos_t pos);
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.key      <= key;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_request(req, key, pos);
  endtask

  // bursty sender: after each burst, an optional gap with valid low
  task automatic send_request(input bmhq_pkg::req_t req, input bmhq_pkg::key_t key,
                              input bmhq_pkg::pos_t pos);
    int gap;
    push_request(req, key, pos);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic bmhq_pkg::key_t pick_key();
    case ($urandom_range(0, 9))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      2, 3, 4: return bmhq_pkg::key_t'($signed($urandom_range(0, 100)) - 50);
      default: return bmhq_pkg::key_t'($urandom);
    endcase
  endfunction

  function automatic bmhq_pkg::pos_t pick_position();
    if (tracker.key_count > 0 && $urandom_range(0, 99) < 85)
      return bmhq_pkg::pos_t'($urandom_range(0, tracker.key_count - 1));
    return bmhq_pkg::pos_t'($urandom_range(0, HEAP_SLOTS - 1));
  endfunction

  // new key for a decrease, mostly smaller than the slot's current key
  function automatic bmhq_pkg::key_t pick_lower_key(bmhq_pkg::pos_t pos);
    longint cur, t;
    if (pos >= tracker.key_count) return pick_key();
    cur = longint'(tracker.heap_keys[pos]);
    case ($urandom_range(0, 9))
      0: t = cur + 1 + $urandom_range(0, 100);
      1: t = cur;
      2: t = longint'(KEY_MIN);
      default: t = cur - $urandom_range(0, 1 << 20);
    endcase
    if (t > longint'(KEY_MAX)) t = longint'(KEY_MAX);
    if (t < longint'(KEY_MIN)) t = longint'(KEY_MIN);
    return bmhq_pkg::key_t'(t);
  endfunction

  task automatic run_phase(input int items, input int insert_pct);
    bmhq_pkg::req_t req;
    bmhq_pkg::key_t key;
    bmhq_pkg::pos_t pos;
    int             sel;
    repeat (items) begin
      pos = pick_position();
      key = pick_key();
      if ($urandom_range(0, 99) < insert_pct) begin
        req = bmhq_pkg::REQ_INSERT;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 30)      req = bmhq_pkg::REQ_EXTRACT;
        else if (sel < 45) req = bmhq_pkg::REQ_PEEK;
        else if (sel < 70) req = bmhq_pkg::REQ_DECREASE;
        else if (sel < 97) req = bmhq_pkg::REQ_DELETE;
        else begin
          case ($urandom_range(0, 2))
            0:       req = REQ_RSVD_A;
            1:       req = REQ_RSVD_B;
            default: req = REQ_RSVD_C;
          endcase
        end
        if (req == bmhq_pkg::REQ_DECREASE) key = pick_lower_key(pos);
      end
      send_request(req, key, pos);
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= bmhq_pkg::REQ_INSERT;
    in_ch.key      <= '0;
    in_ch.position <= '0;
    burst_left     = 4;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty heap: every read or positional request is refused
    send_request(bmhq_pkg::REQ_PEEK, KEY_MAX, '0);
    send_request(bmhq_pkg::REQ_EXTRACT, KEY_MIN, '1);
    send_request(bmhq_pkg::REQ_DECREASE, KEY_MIN, '0);
    send_request(bmhq_pkg::REQ_DELETE, '0, '0);
    // extreme keys, then a small tree
    send_request(bmhq_pkg::REQ_INSERT, KEY_MAX, '0);
    send_request(bmhq_pkg::REQ_INSERT, KEY_MIN, '0);
    send_request(bmhq_pkg::REQ_INSERT, '0, '0);
    send_request(bmhq_pkg::REQ_INSERT, 32'sd5, '0);
    send_request(bmhq_pkg::REQ_PEEK, '0, '0);
    // equal key is fine, larger key refused, smaller key sifts up
    send_request(bmhq_pkg::REQ_DECREASE, tracker.heap_keys[1], 7'd1);
    send_request(bmhq_pkg::REQ_DECREASE, KEY_MAX, 7'd2);
    send_request(bmhq_pkg::REQ_DECREASE, -32'sd7, 7'd3);
    // positions at and beyond the count
    send_request(bmhq_pkg::REQ_DELETE, '0, 7'd4);
    send_request(bmhq_pkg::REQ_DELETE, '0, '1);
    send_request(bmhq_pkg::REQ_DECREASE, KEY_MIN, '1);
    send_request(REQ_RSVD_A, KEY_MAX, '1);
    send_request(REQ_RSVD_B, KEY_MIN, '0);
    send_request(REQ_RSVD_C, '1, '1);
    // delete the root, then the last slot
    send_request(bmhq_pkg::REQ_DELETE, '0, '0);
    send_request(bmhq_pkg::REQ_DELETE, '0, 7'd2);
    send_request(bmhq_pkg::REQ_EXTRACT, '0, '0);
    send_request(bmhq_pkg::REQ_EXTRACT, '0, '0);
    send_request(bmhq_pkg::REQ_EXTRACT, '0, '0);
    send_request(bmhq_pkg::REQ_PEEK, '0, '0);
    drain_results();

    // fill past capacity, churn, drain to empty, fill again, drain
    run_phase(170, 95);
    drain_results();
    run_phase(120, 30);
    run_phase(100, 50);
    run_phase(150, 10);
    drain_results();
    run_phase(100, 70);
    run_phase(80, 50);
    run_phase(150, 95);
    drain_results();
    run_phase(150, 5);

    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("binary_min_heap_queue: match");
    else
      $display("binary_min_heap_queue: mismatch");
    $finish;
  end
endmodule
